// ----- rtl/core/rtm_pkg.sv -----
// Shared types and constants for the ROV thruster mixer.
// Used by the controller, the datapath and the top level; no dependencies.
package rtm_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int AXIS_W   = 16;
  localparam int CODE_W   = 4;
  localparam int PULSE_W  = 12;
  localparam int LIMIT_W  = 11;
  localparam int FS_W     = 15;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 3;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 120;

  localparam int PULSE_MAX = 3000;
  localparam int LIMIT_MAX = 2047;
  localparam int LIMIT_STEP  = 50;
  localparam int REDUCE_STEP = 120;
  localparam int TRIM_STEP   = 5;

  localparam logic [LIMIT_W-1:0] CTRL_UPPER  = 11'd1670;
  localparam logic [LIMIT_W-1:0] CTRL_LOWER  = 11'd1300;
  localparam logic [PULSE_W-1:0] RESET_PULSE = 12'd1500;

  localparam logic [LIMIT_W-1:0] NEUTRAL_RST    = 11'd1500;
  localparam logic [LIMIT_W-1:0] CEILING_RST    = 11'd1730;
  localparam logic [LIMIT_W-1:0] FLOOR_RST      = 11'd1230;
  localparam logic [LIMIT_W-1:0] HV_CEILING_RST = 11'd1750;
  localparam logic [LIMIT_W-1:0] HV_FLOOR_RST   = 11'd1210;
  localparam logic [FS_W-1:0]    FULL_SCALE_RST = 15'd32678;

  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HV_CEILING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HV_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd5;

  typedef enum logic [CODE_W-1:0] {
    CMD_TOGGLE        = 4'd0,
    CMD_ARM           = 4'd1,
    CMD_DISARM        = 4'd2,
    CMD_PITCH_UP      = 4'd3,
    CMD_PITCH_DOWN    = 4'd4,
    CMD_ROLL_UP       = 4'd5,
    CMD_ROLL_DOWN     = 4'd6,
    CMD_LIMIT_UP      = 4'd7,
    CMD_LIMIT_DOWN    = 4'd8,
    CMD_LIMIT_FULL    = 4'd9,
    CMD_LIMIT_REDUCED = 4'd10
  } cmd_code_t;

  // One step of the mixing sequence; order is the execution order.
  typedef enum logic [3:0] {
    OP_SQX, OP_SQY, OP_SQW, OP_MAG,
    OP_H0, OP_H1, OP_H2, OP_H3, OP_HV,
    OP_M0, OP_M1, OP_M2, OP_M3
  } op_t;

  typedef struct packed {
    logic take;
    logic start;
    op_t  op;
    logic latch;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_cmd;
    logic armed;
    logic busy;
    logic done;
  } dp_stat_t;

endpackage

// ----- rtl/core/rtm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Unsigned operands; standalone, no package dependency.
module rtm_div #(
  parameter int DVW = 47,
  parameter int DSW = 30
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int CW = $clog2(DVW + 1);

  logic [DSW-1:0] rem;
  logic [DSW-1:0] dsr;
  logic [CW-1:0]  cnt;
  logic [DSW:0]   shifted;
  logic [DSW:0]   diff;
  logic           ge;

  assign shifted = {rem, quotient[DVW-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        rem      <= '0;
        dsr      <= divisor;
        cnt      <= CW'(DVW);
        busy     <= 1'b1;
      end else if (busy) begin
        quotient <= {quotient[DVW-2:0], ge};
        rem      <= ge ? diff[DSW-1:0] : shifted[DSW-1:0];
        cnt      <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/rtm_sqrt.sv -----
// Iterative integer square root, one root bit per cycle (floor result).
// Standalone, no package dependency.
module rtm_sqrt #(
  parameter int RW = 17
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] operand,
  output logic            busy,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] opr;
  logic [RW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            ge;

  assign rem_sh = {rem[RW-1:0], opr[2*RW-1:2*RW-2]};
  assign trial  = {root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        opr  <= operand;
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(RW);
        busy <= 1'b1;
      end else if (busy) begin
        opr  <= {opr[2*RW-3:0], 2'b00};
        rem  <= ge ? rem_sh - trial : rem_sh;
        root <= {root[RW-2:0], ge};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/rtm_dp.sv -----
// Datapath of the thruster mixer: settings, vehicle state, operand forming,
// shared divider and square root, result registers. Uses rtm_pkg, rtm_div, rtm_sqrt.
module rtm_dp #(
  parameter int FRAC_BITS = rtm_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rtm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtm_pkg::CFG_W-1:0]        cfg_data,
  input  logic [rtm_pkg::IN_TDATA_W-1:0]   in_data,
  input  logic                             in_kind,
  input  rtm_pkg::dp_cmd_t                 cmd,
  output rtm_pkg::dp_stat_t                stat,
  output logic [rtm_pkg::OUT_TDATA_W-1:0]  out_data
);
  import rtm_pkg::*;

  localparam int QW  = FRAC_BITS + 2;
  localparam int RW  = FRAC_BITS + 1;
  localparam int DVW = FRAC_BITS + 31;
  localparam int DSW = (FRAC_BITS + 2 > 30) ? FRAC_BITS + 2 : 30;
  localparam int NW  = DVW + 1;
  localparam int PW  = 29;
  localparam logic [RW-1:0] UNIT = {1'b1, {FRAC_BITS{1'b0}}};

  // settings
  logic [LIMIT_W-1:0] servo_neutral, pwm_ceiling, pwm_floor, heave_ceiling, heave_floor;
  logic [FS_W-1:0]    stick_full_scale;

  // captured item
  logic signed [AXIS_W-1:0] surge, sway, yaw, heave_in;
  logic [CODE_W-1:0]        code;
  logic                     kind;

  // vehicle state
  logic               armed, ctrl_on;
  logic [LIMIT_W-1:0] upper_limit, lower_limit;
  logic [15:0]        pitch_trim, roll_trim;
  logic [PULSE_W-1:0] last_pulse [0:7];

  // work registers
  logic signed [QW-1:0] qx, qy, qw;
  logic [RW-1:0]        pmag;
  logic signed [PW-1:0] hres [0:3];
  logic signed [PW-1:0] zv;
  logic [PULSE_W-1:0]   mres [0:3];
  logic                 q_neg, den_zero;

  function automatic logic [PULSE_W-1:0] sat_pulse(input logic signed [NW-1:0] v);
    logic [PULSE_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > PULSE_MAX) r = PULSE_W'(PULSE_MAX);
    else r = v[PULSE_W-1:0];
    return r;
  endfunction

  function automatic logic [LIMIT_W-1:0] sat_lim(input logic signed [13:0] v);
    logic [LIMIT_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > LIMIT_MAX) r = LIMIT_W'(LIMIT_MAX);
    else r = v[LIMIT_W-1:0];
    return r;
  endfunction

  // ---------------- operand forming ----------------
  logic [FS_W-1:0]          fs;
  logic [2*FS_W-1:0]        fs_sq;
  logic signed [13:0]       n_s, u_s, l_s;

  assign fs    = (stick_full_scale == '0) ? FS_W'(1) : stick_full_scale;
  assign fs_sq = fs * fs;
  assign n_s   = $signed({3'b000, servo_neutral});
  assign u_s   = $signed({3'b000, upper_limit});
  assign l_s   = $signed({3'b000, lower_limit});

  // square law
  logic signed [AXIS_W-1:0] ax_raw;
  logic signed [AXIS_W:0]   ax_w, ax_c, fs_s;
  logic [FS_W-1:0]          a_mag;
  logic [2*FS_W-1:0]        a_sq;
  logic [DVW-1:0]           sq_num;

  always_comb begin
    case (cmd.op)
      OP_SQY:  ax_raw = sway;
      OP_SQW:  ax_raw = yaw;
      default: ax_raw = surge;
    endcase
    ax_w = (AXIS_W+1)'(ax_raw);
    fs_s = $signed({2'b00, fs});
    if (ax_w > fs_s) ax_c = fs_s;
    else if (ax_w < -fs_s) ax_c = -fs_s;
    else ax_c = ax_w;
    a_mag = ax_c[AXIS_W] ? FS_W'(-ax_c) : ax_c[FS_W-1:0];
  end

  assign a_sq   = a_mag * a_mag;
  assign sq_num = (DVW'(a_sq) << FRAC_BITS) + DVW'(fs_sq >> 1);

  // horizontal thrusters
  logic [1:0]             k_h, k_m;
  logic signed [QW:0]     sum_k;
  logic                   pos;
  logic [RW-1:0]          aw;
  logic [RW:0]            den_h;
  logic signed [RW+1:0]   t_h, p_w, w_w;
  logic signed [13:0]     d_h;
  logic [RW+11:0]         nd_h;
  logic signed [RW+15:0]  td_h;
  logic signed [NW-1:0]   num_h;

  assign k_h = 2'(cmd.op - OP_H0);
  assign k_m = 2'(cmd.op - OP_M0);

  always_comb begin
    case (k_h)
      2'd0:    sum_k = (QW+1)'(qx) + (QW+1)'(qy);
      2'd1:    sum_k = (QW+1)'(qy) - (QW+1)'(qx);
      2'd2:    sum_k = (QW+1)'(qx) - (QW+1)'(qy);
      default: sum_k = -(QW+1)'(qx) - (QW+1)'(qy);
    endcase
  end

  assign pos   = !sum_k[QW];
  assign aw    = qw[QW-1] ? RW'(-qw) : qw[RW-1:0];
  assign den_h = {1'b0, UNIT} + {1'b0, aw};
  assign p_w   = $signed({2'b00, pmag});
  assign w_w   = (RW+2)'(qw);
  assign t_h   = pos ? p_w + w_w : p_w - w_w;
  assign d_h   = pos ? u_s - n_s : l_s - n_s;
  assign nd_h  = (RW+12)'(servo_neutral) * (RW+12)'(den_h);
  assign td_h  = t_h * d_h;
  assign num_h = $signed(NW'(nd_h)) + NW'(td_h);

  // heave
  logic signed [13:0]   d_z;
  logic [25:0]          ns_z;
  logic signed [30:0]   zd;
  logic signed [NW-1:0] num_z;

  assign d_z   = heave_in[AXIS_W-1] ? $signed({3'b000, heave_ceiling}) - n_s
                                    : n_s - $signed({3'b000, heave_floor});
  assign ns_z  = 26'(servo_neutral) * 26'(fs);
  assign zd    = heave_in * d_z;
  assign num_z = $signed(NW'(ns_z)) - NW'(zd);

  // mirror about neutral
  logic signed [PW-1:0]  pm;
  logic signed [PW:0]    pn, pdist;
  logic                  gt;
  logic signed [13:0]    fac, mden;
  logic signed [27:0]    nden;
  logic signed [PW+14:0] df;
  logic signed [NW-1:0]  num_m;
  logic [11:0]           dmag_m;

  assign pm     = (cmd.op == OP_M3) ? zv : hres[k_m];
  assign pn     = (PW+1)'(pm) - (PW+1)'(n_s);
  assign gt     = pn > 0;
  assign pdist  = gt ? pn : -pn;
  assign fac    = gt ? l_s - n_s : u_s - n_s;
  assign mden   = gt ? u_s - n_s : n_s - l_s;
  assign nden   = n_s * mden;
  assign df     = pdist * fac;
  assign num_m  = NW'(nden) + NW'(df);
  assign dmag_m = mden[13] ? 12'(-mden) : mden[11:0];

  // operand selection
  logic [DVW-1:0]       div_num;
  logic [DSW-1:0]       div_den;
  logic                 num_neg, den_neg;
  logic signed [NW-1:0] snum;

  always_comb begin
    snum    = '0;
    den_neg = 1'b0;
    div_den = DSW'(fs_sq);
    num_neg = 1'b0;
    div_num = sq_num;
    case (cmd.op)
      OP_SQX, OP_SQY, OP_SQW: begin
        num_neg = ax_c[AXIS_W];
      end
      OP_H0, OP_H1, OP_H2, OP_H3: begin
        snum    = num_h;
        div_den = DSW'(den_h);
      end
      OP_HV: begin
        snum    = num_z;
        div_den = DSW'(fs);
      end
      OP_M0, OP_M1, OP_M2, OP_M3: begin
        snum    = num_m;
        div_den = DSW'(dmag_m);
        den_neg = mden[13];
      end
      default: ;
    endcase
    if (cmd.op != OP_SQX && cmd.op != OP_SQY && cmd.op != OP_SQW) begin
      num_neg = snum[NW-1];
      div_num = num_neg ? DVW'(-snum) : snum[DVW-1:0];
    end
  end

  // ---------------- arithmetic units ----------------
  logic            div_start, sqrt_start;
  logic            div_busy, div_done, sqrt_busy, sqrt_done;
  logic [DVW-1:0]  quo;
  logic [RW-1:0]   root;
  logic [2*RW-1:0] mag_sq;
  logic [RW-1:0]   ax_q, ay_q;

  assign ax_q   = qx[QW-1] ? RW'(-qx) : qx[RW-1:0];
  assign ay_q   = qy[QW-1] ? RW'(-qy) : qy[RW-1:0];
  assign mag_sq = (2*RW)'(ax_q) * (2*RW)'(ax_q) + (2*RW)'(ay_q) * (2*RW)'(ay_q);

  assign div_start  = cmd.start && (cmd.op != OP_MAG);
  assign sqrt_start = cmd.start && (cmd.op == OP_MAG);

  rtm_div #(.DVW(DVW), .DSW(DSW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  rtm_sqrt #(.RW(RW)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .operand (mag_sq),
    .busy    (sqrt_busy),
    .done    (sqrt_done),
    .root    (root)
  );

  assign stat.is_cmd = kind;
  assign stat.armed  = armed;
  assign stat.busy   = div_busy | sqrt_busy;
  assign stat.done   = div_done | sqrt_done;

  logic signed [NW-1:0] qres;
  assign qres = q_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // ---------------- commit values ----------------
  logic               armed_next, ctrl_on_next;
  logic [LIMIT_W-1:0] upper_next, lower_next;
  logic [15:0]        pitch_next, roll_next;
  logic [PULSE_W-1:0] pulse_next [0:7];
  logic signed [13:0] uw, lw;

  always_comb begin
    armed_next   = armed;
    ctrl_on_next = ctrl_on;
    upper_next   = upper_limit;
    lower_next   = lower_limit;
    pitch_next   = pitch_trim;
    roll_next    = roll_trim;
    uw = '0;
    lw = '0;
    for (int i = 0; i < 8; i++) pulse_next[i] = last_pulse[i];
    if (kind) begin
      case (code)
        CMD_TOGGLE: begin
          ctrl_on_next = !ctrl_on;
          upper_next   = ctrl_on ? pwm_ceiling : CTRL_UPPER;
          lower_next   = ctrl_on ? pwm_floor : CTRL_LOWER;
        end
        CMD_ARM:        armed_next = 1'b1;
        CMD_DISARM:     armed_next = 1'b0;
        CMD_PITCH_UP:   pitch_next = pitch_trim + 16'(TRIM_STEP);
        CMD_PITCH_DOWN: pitch_next = pitch_trim - 16'(TRIM_STEP);
        CMD_ROLL_UP:    roll_next  = roll_trim + 16'(TRIM_STEP);
        CMD_ROLL_DOWN:  roll_next  = roll_trim - 16'(TRIM_STEP);
        CMD_LIMIT_UP: begin
          uw = u_s + 14'(LIMIT_STEP);
          lw = l_s - 14'(LIMIT_STEP);
          if (uw > $signed({3'b000, pwm_ceiling})) uw = $signed({3'b000, pwm_ceiling});
          if (lw < $signed({3'b000, pwm_floor})) lw = $signed({3'b000, pwm_floor});
          upper_next = sat_lim(uw);
          lower_next = sat_lim(lw);
        end
        CMD_LIMIT_DOWN: begin
          uw = u_s - 14'(LIMIT_STEP);
          lw = l_s + 14'(LIMIT_STEP);
          if (uw < n_s + 14'(LIMIT_STEP)) uw = n_s + 14'(LIMIT_STEP);
          if (lw > n_s - 14'(LIMIT_STEP)) lw = n_s - 14'(LIMIT_STEP);
          upper_next = sat_lim(uw);
          lower_next = sat_lim(lw);
        end
        CMD_LIMIT_FULL: begin
          upper_next = pwm_ceiling;
          lower_next = pwm_floor;
        end
        CMD_LIMIT_REDUCED: begin
          uw = $signed({3'b000, pwm_ceiling}) - 14'(REDUCE_STEP);
          lw = $signed({3'b000, pwm_floor}) + 14'(REDUCE_STEP);
          upper_next = sat_lim(uw);
          lower_next = sat_lim(lw);
        end
        default: ;
      endcase
    end else begin
      pulse_next[0] = mres[0];
      pulse_next[1] = mres[1];
      pulse_next[2] = mres[2];
      pulse_next[3] = sat_pulse(NW'(hres[3]));
      pulse_next[4] = sat_pulse(NW'(zv));
      pulse_next[5] = sat_pulse(NW'(zv));
      pulse_next[6] = sat_pulse(NW'(zv));
      pulse_next[7] = mres[3];
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      servo_neutral    <= NEUTRAL_RST;
      pwm_ceiling      <= CEILING_RST;
      pwm_floor        <= FLOOR_RST;
      heave_ceiling    <= HV_CEILING_RST;
      heave_floor      <= HV_FLOOR_RST;
      stick_full_scale <= FULL_SCALE_RST;
      armed            <= 1'b0;
      ctrl_on          <= 1'b0;
      upper_limit      <= CEILING_RST;
      lower_limit      <= FLOOR_RST;
      pitch_trim       <= '0;
      roll_trim        <= '0;
      for (int i = 0; i < 8; i++) last_pulse[i] <= RESET_PULSE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEUTRAL:    servo_neutral    <= cfg_data[LIMIT_W-1:0];
          CFG_CEILING:    pwm_ceiling      <= cfg_data[LIMIT_W-1:0];
          CFG_FLOOR:      pwm_floor        <= cfg_data[LIMIT_W-1:0];
          CFG_HV_CEILING: heave_ceiling    <= cfg_data[LIMIT_W-1:0];
          CFG_HV_FLOOR:   heave_floor      <= cfg_data[LIMIT_W-1:0];
          CFG_FULL_SCALE: stick_full_scale <= cfg_data[FS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        armed       <= armed_next;
        ctrl_on     <= ctrl_on_next;
        upper_limit <= upper_next;
        lower_limit <= lower_next;
        pitch_trim  <= pitch_next;
        roll_trim   <= roll_next;
        for (int i = 0; i < 8; i++) last_pulse[i] <= pulse_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      surge    <= in_data[15:0];
      sway     <= in_data[31:16];
      yaw      <= in_data[47:32];
      heave_in <= in_data[63:48];
      code     <= in_data[67:64];
      kind     <= in_kind;
    end
    // sign and zero-divisor flags follow the operands into the divider
    if (cmd.start) begin
      q_neg    <= num_neg ^ den_neg;
      den_zero <= (cmd.op == OP_M0 || cmd.op == OP_M1 || cmd.op == OP_M2 ||
                   cmd.op == OP_M3) && (mden == '0);
    end
    if (cmd.latch) begin
      case (cmd.op)
        OP_SQX: qx <= qres[QW-1:0];
        OP_SQY: qy <= qres[QW-1:0];
        OP_SQW: qw <= qres[QW-1:0];
        OP_MAG: pmag <= (root > UNIT) ? UNIT : root;
        OP_H0, OP_H1, OP_H2, OP_H3: hres[k_h] <= qres[PW-1:0];
        OP_HV:  zv <= qres[PW-1:0];
        OP_M0, OP_M1, OP_M2, OP_M3:
          mres[k_m] <= den_zero ? PULSE_W'(servo_neutral) : sat_pulse(qres);
        default: ;
      endcase
    end
    if (cmd.commit) begin
      out_data <= {lower_next, upper_next, ctrl_on_next, armed_next,
                   pulse_next[7], pulse_next[6], pulse_next[5], pulse_next[4],
                   pulse_next[3], pulse_next[2], pulse_next[1], pulse_next[0]};
    end
  end

endmodule

// ----- rtl/core/rtm_ctrl.sv -----
// Sequencer of the thruster mixer: accepts items, steps the datapath through
// the mixing operations and owns the result handshake. Uses rtm_pkg.
module rtm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  rtm_pkg::dp_stat_t stat,
  output rtm_pkg::dp_cmd_t  cmd
);
  import rtm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_START, S_WAIT, S_LATCH, S_COMMIT
  } state_t;

  state_t state;
  op_t    op;
  logic   out_free;

  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);
  assign cmd.take   = (state == S_IDLE) && in_valid;
  assign cmd.start  = (state == S_START);
  assign cmd.latch  = (state == S_LATCH);
  assign cmd.commit = (state == S_COMMIT) && out_free;
  assign cmd.op     = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_SQX;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          // drop axes while disarmed
          if (stat.is_cmd) state <= S_COMMIT;
          else if (stat.armed) begin
            op    <= OP_SQX;
            state <= S_START;
          end else state <= S_IDLE;
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (stat.done) state <= S_LATCH;
        end
        S_LATCH: begin
          if (op == OP_M3) state <= S_COMMIT;
          else begin
            op    <= op_t'(op + 4'd1);
            state <= S_START;
          end
        end
        S_COMMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !stat.busy) else $error("arithmetic unit busy while idle");

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !stat.busy) else $error("unit started while busy");

  a_latch_after_done: assert property (@(posedge clk) disable iff (rst)
    state == S_LATCH |-> $past(stat.done)) else $error("result latched before done");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid) else $error("committed result not presented");

endmodule

// ----- rtl/core/rov_thruster_mixer_top.sv -----
// Top level of the ROV thruster mixer: joins the sequencer and the datapath.
// Uses rtm_pkg, rtm_ctrl, rtm_dp.
//
// Input stream (s_axis_*): one transaction per item. s_axis_tuser is the item
// kind (0 joystick axes, 1 command); s_axis_tdata carries the axes and the
// command code. Output stream (m_axis_*): one transaction per result, carrying
// the eight thruster pulses, the armed and controller flags and both limits.
// The user must write settings through cfg_we/cfg_index/cfg_data only while
// the block idles; the block itself does not enforce this. A command item
// passes from acceptance through the decide step to its commit step. An
// armed axes item runs twelve divisions on one shared divider and one square
// root. Axes while disarmed give no result. One item is in work at a time;
// the next is taken as soon as the result sits in the output register, even
// while that result is still held. A stalled receiver holds the result; the
// following item then waits at its commit step. Reset restores the default
// settings, disarms, selects manual limits and sets every stored pulse to
// 1500.
module rov_thruster_mixer_top #(
  parameter int FRAC_BITS = rtm_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // surge_axis, sway_axis, yaw_axis, heave_axis, command_code, zero pad
  input  logic [rtm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // front_right_pwm, front_left_pwm, rear_right_pwm, rear_left_pwm,
  // up_front_right_pwm, up_rear_left_pwm, up_rear_right_pwm, up_front_left_pwm,
  // armed_flag, controller_mode, upper_limit_now, lower_limit_now
  output logic [rtm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [rtm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtm_pkg::CFG_W-1:0]       cfg_data
);
  import rtm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rtm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .stat      (stat),
    .cmd       (cmd)
  );

  rtm_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_kind   (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for rov_thruster_mixer_top: streams joystick and
// command items with random gaps and stalls, predicts every result in a
// scoreboard class. Depends on rtm_pkg and the top level only.
module testbench;
  import rtm_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 2000;

  class mixer_scoreboard;
    longint neutral, ceiling, floor_lim, hv_ceiling, hv_floor, full_scale;
    bit armed, ctrl_on;
    longint upper, lower;
    logic [15:0] pitch_trim, roll_trim;
    logic [PULSE_W-1:0] pulses[8];
    logic [OUT_TDATA_W-1:0] pending[$];
    int errors;
    int results_seen;

    function void reset_state();
      neutral = NEUTRAL_RST; ceiling = CEILING_RST; floor_lim = FLOOR_RST;
      hv_ceiling = HV_CEILING_RST; hv_floor = HV_FLOOR_RST; full_scale = FULL_SCALE_RST;
      armed = 0; ctrl_on = 0; upper = CEILING_RST; lower = FLOOR_RST;
      pitch_trim = 0; roll_trim = 0;
      for (int i = 0; i < 8; i++) pulses[i] = RESET_PULSE;
      errors = 0; results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_NEUTRAL:    neutral = val[10:0];
        CFG_CEILING:    ceiling = val[10:0];
        CFG_FLOOR:      floor_lim = val[10:0];
        CFG_HV_CEILING: hv_ceiling = val[10:0];
        CFG_HV_FLOOR:   hv_floor = val[10:0];
        CFG_FULL_SCALE: full_scale = val[14:0];
        default: ;
      endcase
    endfunction

    function longint fs_eff();
      return (full_scale == 0) ? 1 : full_scale;
    endfunction

    function longint sat_pw(longint v);
      if (v < 0) return 0;
      if (v > PULSE_MAX) return PULSE_MAX;
      return v;
    endfunction

    function longint sat_lim(longint v);
      if (v < 0) return 0;
      if (v > LIMIT_MAX) return LIMIT_MAX;
      return v;
    endfunction

    function longint shape_axis(logic signed [15:0] raw);
      longint s, x, a, den, q;
      s = fs_eff();
      x = raw;
      if (x > s) x = s;
      if (x < -s) x = -s;
      a = (x < 0) ? -x : x;
      den = s * s;
      q = (((a * a) << FB) + den / 2) / den;
      return (x > 0) ? q : -q;
    endfunction

    function longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint mirror(longint p);
      longint num, den;
      if (p > neutral) begin
        den = upper - neutral;
        num = neutral * den - (p - neutral) * (neutral - lower);
      end else begin
        den = neutral - lower;
        num = neutral * den + (neutral - p) * (upper - neutral);
      end
      if (den == 0) return neutral;
      return num / den;
    endfunction

    function longint horiz_pulse(longint sum, longint power, longint w, longint den);
      longint t, d;
      if (sum >= 0) begin
        t = power + w; d = upper - neutral;
      end else begin
        t = power - w; d = lower - neutral;
      end
      return (neutral * den + t * d) / den;
    endfunction

    function longint heave_pulse(logic signed [15:0] raw);
      longint s, z, d;
      s = fs_eff();
      z = raw;
      d = (z < 0) ? hv_ceiling - neutral : neutral - hv_floor;
      return (neutral * s - z * d) / s;
    endfunction

    function void run_command(logic [CODE_W-1:0] code);
      longint u, l;
      case (code)
        CMD_TOGGLE: begin
          ctrl_on = !ctrl_on;
          if (ctrl_on) begin
            upper = CTRL_UPPER; lower = CTRL_LOWER;
          end else begin
            upper = ceiling; lower = floor_lim;
          end
        end
        CMD_ARM:        armed = 1;
        CMD_DISARM:     armed = 0;
        CMD_PITCH_UP:   pitch_trim += TRIM_STEP;
        CMD_PITCH_DOWN: pitch_trim -= TRIM_STEP;
        CMD_ROLL_UP:    roll_trim += TRIM_STEP;
        CMD_ROLL_DOWN:  roll_trim -= TRIM_STEP;
        CMD_LIMIT_UP: begin
          u = upper + LIMIT_STEP; l = lower - LIMIT_STEP;
          if (u > ceiling) u = ceiling;
          if (l < floor_lim) l = floor_lim;
          upper = sat_lim(u); lower = sat_lim(l);
        end
        CMD_LIMIT_DOWN: begin
          u = upper - LIMIT_STEP; l = lower + LIMIT_STEP;
          if (u < neutral + LIMIT_STEP) u = neutral + LIMIT_STEP;
          if (l > neutral - LIMIT_STEP) l = neutral - LIMIT_STEP;
          upper = sat_lim(u); lower = sat_lim(l);
        end
        CMD_LIMIT_FULL: begin
          upper = ceiling; lower = floor_lim;
        end
        CMD_LIMIT_REDUCED: begin
          upper = sat_lim(ceiling - REDUCE_STEP);
          lower = sat_lim(floor_lim + REDUCE_STEP);
        end
        default: ;
      endcase
    endfunction

    // Note an accepted input transaction and queue its result, if any.
    function void note_input(bit is_cmd, logic [IN_TDATA_W-1:0] d);
      longint x, y, w, aw, den, power, z;
      logic [OUT_TDATA_W-1:0] r;
      if (is_cmd) begin
        run_command(d[67:64]);
      end else begin
        if (!armed) return;
        x = shape_axis(d[15:0]);
        y = shape_axis(d[31:16]);
        w = shape_axis(d[47:32]);
        power = int_sqrt(x * x + y * y);
        if (power > (64'sd1 << FB)) power = 64'sd1 << FB;
        aw = (w < 0) ? -w : w;
        den = (64'sd1 << FB) + aw;
        pulses[0] = PULSE_W'(sat_pw(mirror(horiz_pulse(x + y, power, w, den))));
        pulses[1] = PULSE_W'(sat_pw(mirror(horiz_pulse(-x + y, power, w, den))));
        pulses[2] = PULSE_W'(sat_pw(mirror(horiz_pulse(x - y, power, w, den))));
        pulses[3] = PULSE_W'(sat_pw(horiz_pulse(-x - y, power, w, den)));
        z = heave_pulse(d[63:48]);
        pulses[4] = PULSE_W'(sat_pw(z));
        pulses[5] = PULSE_W'(sat_pw(z));
        pulses[6] = PULSE_W'(sat_pw(z));
        pulses[7] = PULSE_W'(sat_pw(mirror(z)));
      end
      for (int i = 0; i < 8; i++) r[i*12 +: 12] = pulses[i];
      r[96] = armed;
      r[97] = ctrl_on;
      r[108:98] = upper[10:0];
      r[119:109] = lower[10:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] act);
      logic [OUT_TDATA_W-1:0] exp_r;
      string names[8];
      names = '{"front_right_pwm", "front_left_pwm", "rear_right_pwm", "rear_left_pwm",
                "up_front_right_pwm", "up_rear_left_pwm", "up_rear_right_pwm",
                "up_front_left_pwm"};
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result transaction %h", act);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      for (int i = 0; i < 8; i++)
        if (act[i*12 +: 12] !== exp_r[i*12 +: 12]) begin
          $error("%s: expected %0d, got %0d", names[i], exp_r[i*12 +: 12], act[i*12 +: 12]);
          errors++;
        end
      if (act[96] !== exp_r[96]) begin
        $error("armed_flag: expected %0d, got %0d", exp_r[96], act[96]);
        errors++;
      end
      if (act[97] !== exp_r[97]) begin
        $error("controller_mode: expected %0d, got %0d", exp_r[97], act[97]);
        errors++;
      end
      if (act[108:98] !== exp_r[108:98]) begin
        $error("upper_limit_now: expected %0d, got %0d", exp_r[108:98], act[108:98]);
        errors++;
      end
      if (act[119:109] !== exp_r[119:109]) begin
        $error("lower_limit_now: expected %0d, got %0d", exp_r[119:109], act[119:109]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mixer_scoreboard sb;
  int cycles;
  bit hold_rx;
  int axes_sent, cmds_sent;

  rov_thruster_mixer_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: random stall per result, one long hold-off on request.
  initial begin
    int stall;
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        m_axis_tready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
      m_axis_tready <= 0;
    end
  end

  task automatic send_item(bit is_cmd, logic [15:0] sx, logic [15:0] sy,
                           logic [15:0] yw, logic [15:0] hv, logic [3:0] code,
                           bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= is_cmd;
    s_axis_tdata <= {4'b0, code, hv, yw, sy, sx};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(is_cmd, {4'b0, code, hv, yw, sy, sx});
    if (is_cmd) cmds_sent++; else axes_sent++;
  endtask

  task automatic send_cmd(cmd_code_t c);
    send_item(1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), c);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 600)) - 300);
      3: return 16'(sb.fs_eff());
      4: return 16'(-sb.fs_eff());
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_axes(bit no_gap = 0);
    send_item(0, pick_axis(), pick_axis(), pick_axis(), pick_axis(), 4'($urandom), no_gap);
  endtask

  // Wait for every expected result, then let a disarmed item finish too.
  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(int phase);
    case (phase)
      1: begin
        write_reg(CFG_NEUTRAL, 1000); write_reg(CFG_CEILING, 1500);
        write_reg(CFG_FLOOR, 1000); write_reg(CFG_HV_CEILING, 1500);
        write_reg(CFG_HV_FLOOR, 1000); write_reg(CFG_FULL_SCALE, 1);
      end
      2: begin
        write_reg(CFG_NEUTRAL, 2000); write_reg(CFG_CEILING, 2000);
        write_reg(CFG_FLOOR, 1500); write_reg(CFG_HV_CEILING, 2000);
        write_reg(CFG_HV_FLOOR, 1500); write_reg(CFG_FULL_SCALE, 32767);
      end
      default: begin
        write_reg(CFG_NEUTRAL, CFG_W'($urandom_range(1000, 2000)));
        write_reg(CFG_CEILING, CFG_W'($urandom_range(1500, 2000)));
        write_reg(CFG_FLOOR, CFG_W'($urandom_range(1000, 1500)));
        write_reg(CFG_HV_CEILING, CFG_W'($urandom_range(1500, 2000)));
        write_reg(CFG_HV_FLOOR, CFG_W'($urandom_range(1000, 1500)));
        write_reg(CFG_FULL_SCALE, CFG_W'(($urandom_range(0, 1) == 0) ?
                  $urandom_range(1, 32767) : $urandom_range(20000, 32767)));
      end
    endcase
    cfg_we <= 0;
    @(posedge clk);
  endtask

  initial begin
    int n;
    sb = new();
    sb.reset_state();
    hold_rx = 0;
    axes_sent = 0; cmds_sent = 0;
    rst = 1;
    s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = '0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: disarmed axes ignored, then every command and the axis extremes.
    send_item(0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 4'h0);
    send_cmd(CMD_ARM);
    send_item(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0);
    send_item(0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'hF);
    send_item(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'h0);
    send_item(0, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 4'h0);
    for (int c = 0; c < 16; c++)
      if (c != CMD_DISARM) send_item(1, 16'hFFFF, 0, 16'hFFFF, 0, 4'(c));
    send_item(0, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 4'h0);
    send_cmd(CMD_DISARM);
    send_item(0, 16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, 4'h0);
    send_cmd(CMD_ARM);
    drain();

    for (int phase = 1; phase <= 6; phase++) begin
      apply_setting(phase);
      if (phase == 3) begin
        // Long receiver hold-off while the sender keeps offering.
        hold_rx = 1;
        for (int i = 0; i < 12; i++) send_axes(1);
      end
      n = 0;
      while (n < 130) begin
        case ($urandom_range(0, 19))
          0:       send_cmd(CMD_DISARM);
          1, 2:    send_cmd(CMD_ARM);
          3, 4:    send_item(1, 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 4'($urandom));
          5:       send_cmd(cmd_code_t'($urandom_range(CMD_LIMIT_UP, CMD_LIMIT_REDUCED)));
          6:       send_cmd(CMD_TOGGLE);
          default: send_axes();
        endcase
        n++;
      end
      drain();
    end

    $display("Covered %0d axes and %0d command items over 7 settings, %0d results checked",
             axes_sent, cmds_sent, sb.results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
